>>> sv/pau_pkg.sv
// Shared types and constants for the Pareto archive update block.
package pau_pkg;

    localparam int FRONT_DEPTH_DEF = 16;
    localparam int MAX_CAT_DEF     = 4;
    localparam int COST_WIDTH_DEF  = 16;

    localparam int IN_LANES  = 4;
    localparam int VAL_W     = 16;
    localparam int TAG_W     = 16;
    localparam int IDX_W     = 4;
    localparam int CNT_OUT_W = 5;
    localparam int CFG_W     = 3;
    localparam int LANE_W    = 4;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // register byte offsets, only bit 2 selects a register
    localparam logic [2:0] ADDR_ACTIVE_CAT = 3'd0;
    localparam logic [CFG_W-1:0] ACTIVE_CAT_RST = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_READ,
        S_FIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic walk;
        logic rd_en;
        logic fin;
    } t_ctl;

    typedef struct packed {
        logic walk_done;
        logic out_free;
    } t_sts;

endpackage

>>> sv/pau_ctrl.sv
// Sequencer: item dispatch, archive walk, commit and result handoff.
module pau_ctrl
    import pau_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_cmd,
    input  t_sts       i_sts,
    output logic       o_ready,
    output t_ctl       o_ctl,
    output logic       o_load
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_ready = 1'b0;
        o_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctl.start = 1'b1;
                    case (i_cmd) inside
                        CMD_INSERT, CMD_QUERY: n_state = S_WALK;
                        CMD_READ:              n_state = S_READ;
                        default:               n_state = S_FIN;
                    endcase
                end
            end
            S_WALK: begin
                o_ctl.walk = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = S_FIN;
                end
            end
            S_READ: begin
                o_ctl.rd_en = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                o_ctl.fin = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

>>> sv/pau_dp.sv
// Datapath: archive memory, dominance compare, compaction pointers, results.
module pau_dp
    import pau_pkg::*;
#(
    parameter int FRONT_DEPTH    = FRONT_DEPTH_DEF,
    parameter int MAX_CATEGORIES = MAX_CAT_DEF,
    parameter int COST_WIDTH     = COST_WIDTH_DEF
)
(
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_ctl                             i_ctl,
    input  logic [1:0]                       i_cmd,
    input  logic [TAG_W-1:0]                 i_tag,
    input  logic [IN_LANES-1:0][VAL_W-1:0]   i_vals,
    input  logic [IDX_W-1:0]                 i_idx,
    input  logic [CFG_W-1:0]                 i_act_cat,
    output logic                             o_walk_done,
    output logic                             o_accepted,
    output logic                             o_overflow,
    output logic [CNT_OUT_W-1:0]             o_removed,
    output logic                             o_explore,
    output logic [CNT_OUT_W-1:0]             o_front_size,
    output logic                             o_read_valid,
    output logic [TAG_W-1:0]                 o_read_tag,
    output logic [IN_LANES-1:0][VAL_W-1:0]   o_read_cost
);

    localparam int AW = (FRONT_DEPTH > 1) ? $clog2(FRONT_DEPTH) : 1;
    localparam int CW = $clog2(FRONT_DEPTH + 1);
    localparam int VW = MAX_CATEGORIES * COST_WIDTH;
    localparam int EW = VW + TAG_W;

    logic [EW-1:0] mem [FRONT_DEPTH];
    logic [EW-1:0] r_rdata;

    logic [1:0]                                r_cmd;
    logic [TAG_W-1:0]                          r_tag;
    logic [MAX_CATEGORIES-1:0][COST_WIDTH-1:0] r_vec;
    logic [IDX_W-1:0]                          r_idx;
    logic [CW-1:0]                             r_cnt;
    logic [CW-1:0]                             r_rd;
    logic [CW-1:0]                             r_wr;
    logic [CW-1:0]                             r_rem;
    logic                                      r_pv;
    logic                                      r_rej;
    logic                                      r_expl;

    logic                  r_res_acc;
    logic                  r_res_ovf;
    logic [CW-1:0]         r_res_rem;
    logic                  r_res_expl;
    logic [CW-1:0]         r_res_size;
    logic                  r_res_rv;
    logic [EW-1:0]         r_res_data;

    logic [MAX_CATEGORIES-1:0][COST_WIDTH-1:0] in_vec;
    logic [MAX_CATEGORIES-1:0][COST_WIDTH-1:0] e_vec;
    logic [MAX_CATEGORIES-1:0]                 lane_on;
    logic [LANE_W-1:0]                         lanes;
    logic                                      cov_new;
    logic                                      cov_ent;
    logic                                      rd_more;
    logic                                      wr_room;
    logic                                      do_append;
    logic [CW-1:0]                             fin_cnt;
    logic [CW+IDX_W-1:0]                       idx_ext;
    logic [CW+IDX_W-1:0]                       cnt_ext;
    logic                                      idx_ok;
    logic [CW+CNT_OUT_W-1:0]                   rem_ext;
    logic [CW+CNT_OUT_W-1:0]                   size_ext;

    logic          mem_re;
    logic [AW-1:0] mem_ra;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [EW-1:0] mem_wd;

    // input lanes, masked or widened to the cost width; lanes past the inputs are zero
    for (genvar k = 0; k < MAX_CATEGORIES; k++) begin : g_in_lane
        if (k < IN_LANES) begin : g_val
            logic [COST_WIDTH+VAL_W-1:0] w_ext;
            assign w_ext     = {{COST_WIDTH{1'b0}}, i_vals[k]};
            assign in_vec[k] = w_ext[COST_WIDTH-1:0];
        end else begin : g_zero
            assign in_vec[k] = '0;
        end
    end

    always_comb begin
        if (i_act_cat == '0) begin
            lanes = LANE_W'(1);
        end else if ({1'b0, i_act_cat} > LANE_W'(MAX_CATEGORIES)) begin
            lanes = LANE_W'(MAX_CATEGORIES);
        end else begin
            lanes = {1'b0, i_act_cat};
        end
    end

    assign e_vec = r_rdata[VW-1:0];

    always_comb begin
        cov_new = 1'b1;
        cov_ent = 1'b1;
        for (int k = 0; k < MAX_CATEGORIES; k++) begin
            lane_on[k] = (LANE_W'(k) < lanes);
            if (lane_on[k]) begin
                if (r_vec[k] < e_vec[k]) cov_new = 1'b0;
                if (e_vec[k] < r_vec[k]) cov_ent = 1'b0;
            end
        end
    end

    assign rd_more     = (r_rd < r_cnt);
    assign o_walk_done = !rd_more && !r_pv;
    assign wr_room     = (r_wr < CW'(FRONT_DEPTH));
    assign do_append   = (r_cmd == CMD_INSERT) && !r_rej && wr_room;
    assign fin_cnt     = (r_cmd == CMD_INSERT) ? (do_append ? r_wr + CW'(1) : r_wr) : r_cnt;
    assign idx_ext     = {{CW{1'b0}}, r_idx};
    assign cnt_ext     = {{IDX_W{1'b0}}, r_cnt};
    assign idx_ok      = (idx_ext < cnt_ext);

    // memory port control: sequential reads during the walk, an indexed read for a read
    // command, kept entries written back at the compaction pointer, append at commit
    always_comb begin
        mem_re = 1'b0;
        mem_ra = r_rd[AW-1:0];
        mem_we = 1'b0;
        mem_wa = r_wr[AW-1:0];
        mem_wd = r_rdata;
        if (i_ctl.walk) begin
            mem_re = rd_more;
            mem_we = r_pv && (r_cmd == CMD_INSERT) && (r_rej || !cov_new);
        end
        if (i_ctl.rd_en) begin
            mem_re = 1'b1;
            mem_ra = idx_ext[AW-1:0];
        end
        if (i_ctl.fin && do_append) begin
            mem_we = 1'b1;
            mem_wd = {r_tag, r_vec};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        if (mem_re) r_rdata <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_pv  <= 1'b0;
        end else begin
            if (i_ctl.start) begin
                r_pv <= 1'b0;
            end else if (i_ctl.walk) begin
                r_pv <= rd_more;
            end
            if (i_ctl.fin) begin
                r_cnt <= fin_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_cmd  <= i_cmd;
            r_tag  <= i_tag;
            r_vec  <= in_vec;
            r_idx  <= i_idx;
            r_rd   <= '0;
            r_wr   <= '0;
            r_rem  <= '0;
            r_rej  <= 1'b0;
            r_expl <= (r_cnt == '0);
        end else if (i_ctl.walk) begin
            if (rd_more) r_rd <= r_rd + CW'(1);
            if (r_pv) begin
                if (r_cmd == CMD_INSERT) begin
                    if (!r_rej && cov_new) begin
                        r_rem <= r_rem + CW'(1);
                    end else begin
                        if (!r_rej && cov_ent) r_rej <= 1'b1;
                        r_wr <= r_wr + CW'(1);
                    end
                end else if (!cov_ent) begin
                    // bound beats this entry in some lane
                    r_expl <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fin) begin
            r_res_acc  <= 1'b0;
            r_res_ovf  <= 1'b0;
            r_res_rem  <= '0;
            r_res_expl <= 1'b0;
            r_res_rv   <= 1'b0;
            r_res_data <= '0;
            r_res_size <= fin_cnt;
            case (r_cmd)
                CMD_INSERT: begin
                    r_res_acc <= do_append;
                    r_res_ovf <= !r_rej && !wr_room;
                    r_res_rem <= r_rem;
                end
                CMD_QUERY: r_res_expl <= r_expl;
                CMD_READ: begin
                    r_res_rv <= idx_ok;
                    if (idx_ok) r_res_data <= r_rdata;
                end
                default: ;
            endcase
        end
    end

    assign rem_ext      = {{CNT_OUT_W{1'b0}}, r_res_rem};
    assign size_ext     = {{CNT_OUT_W{1'b0}}, r_res_size};
    assign o_accepted   = r_res_acc;
    assign o_overflow   = r_res_ovf;
    assign o_removed    = rem_ext[CNT_OUT_W-1:0];
    assign o_explore    = r_res_expl;
    assign o_front_size = size_ext[CNT_OUT_W-1:0];
    assign o_read_valid = r_res_rv;
    assign o_read_tag   = r_res_data[EW-1 -: TAG_W];

    for (genvar k = 0; k < IN_LANES; k++) begin : g_out_lane
        if (k < MAX_CATEGORIES) begin : g_cost
            logic [COST_WIDTH+VAL_W-1:0] w_ext;
            assign w_ext          = {{VAL_W{1'b0}}, r_res_data[k*COST_WIDTH +: COST_WIDTH]};
            assign o_read_cost[k] = w_ext[VAL_W-1:0];
        end else begin : g_zero
            assign o_read_cost[k] = '0;
        end
    end

endmodule

>>> sv/pareto_archive_update.sv
// Top level: Pareto archive with insert, prune query and read commands.
//
//   channel   direction  handshake              payload
//   command   in         i_valid / o_ready      i_cmd, i_solution_tag, i_value_0..3,
//                                               i_read_index
//   result    out        o_valid / i_ready      o_accepted .. o_read_cost_3
//   config    in         psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// Insert/query: a walk reads, compares and writes back one entry per cycle on separate
// read and write ports, then commit and handoff. Read: an indexed read, then commit and
// handoff; unknown: commit and handoff only.
// One item in work at a time; the next is accepted once the result is loaded.
// Reset empties the archive and sets active_categories to 4; no clearing pass.
// A stalled result holds the sequencer in its handoff state, blocking new items.
module pareto_archive_update
    import pau_pkg::*;
#(
    parameter int FRONT_DEPTH    = FRONT_DEPTH_DEF,
    parameter int MAX_CATEGORIES = MAX_CAT_DEF,
    parameter int COST_WIDTH     = COST_WIDTH_DEF
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_cmd,
    input  logic [TAG_W-1:0]     i_solution_tag,
    input  logic [VAL_W-1:0]     i_value_0,
    input  logic [VAL_W-1:0]     i_value_1,
    input  logic [VAL_W-1:0]     i_value_2,
    input  logic [VAL_W-1:0]     i_value_3,
    input  logic [IDX_W-1:0]     i_read_index,

    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_accepted,
    output logic                 o_overflow,
    output logic [CNT_OUT_W-1:0] o_removed_count,
    output logic                 o_explore,
    output logic [CNT_OUT_W-1:0] o_front_size,
    output logic                 o_read_valid,
    output logic [TAG_W-1:0]     o_read_tag,
    output logic [VAL_W-1:0]     o_read_cost_0,
    output logic [VAL_W-1:0]     o_read_cost_1,
    output logic [VAL_W-1:0]     o_read_cost_2,
    output logic [VAL_W-1:0]     o_read_cost_3,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [CFG_W-1:0] r_act_cat;

    t_ctl ctl;
    t_sts sts;
    logic load;
    logic walk_done;

    logic [IN_LANES-1:0][VAL_W-1:0] vals;
    logic [IN_LANES-1:0][VAL_W-1:0] dp_cost;
    logic                           dp_acc;
    logic                           dp_ovf;
    logic [CNT_OUT_W-1:0]           dp_rem;
    logic                           dp_expl;
    logic [CNT_OUT_W-1:0]           dp_size;
    logic                           dp_rv;
    logic [TAG_W-1:0]               dp_tag;

    logic                           r_ovalid;
    logic                           r_acc;
    logic                           r_ovf;
    logic [CNT_OUT_W-1:0]           r_rem;
    logic                           r_expl;
    logic [CNT_OUT_W-1:0]           r_size;
    logic                           r_rv;
    logic [TAG_W-1:0]               r_tag;
    logic [IN_LANES-1:0][VAL_W-1:0] r_cost;

    // configuration register
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_cat <= ACTIVE_CAT_RST;
        end else if (psel && penable && pwrite && (paddr[2] == ADDR_ACTIVE_CAT[2])) begin
            r_act_cat <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == ADDR_ACTIVE_CAT[2]) ? {{(32-CFG_W){1'b0}}, r_act_cat} : '0;

    assign vals = {i_value_3, i_value_2, i_value_1, i_value_0};

    assign sts.walk_done = walk_done;
    assign sts.out_free  = !r_ovalid || i_ready;

    pau_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .i_sts   (sts),
        .o_ready (o_ready),
        .o_ctl   (ctl),
        .o_load  (load)
    );

    pau_dp #(
        .FRONT_DEPTH    (FRONT_DEPTH),
        .MAX_CATEGORIES (MAX_CATEGORIES),
        .COST_WIDTH     (COST_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_cmd        (i_cmd),
        .i_tag        (i_solution_tag),
        .i_vals       (vals),
        .i_idx        (i_read_index),
        .i_act_cat    (r_act_cat),
        .o_walk_done  (walk_done),
        .o_accepted   (dp_acc),
        .o_overflow   (dp_ovf),
        .o_removed    (dp_rem),
        .o_explore    (dp_expl),
        .o_front_size (dp_size),
        .o_read_valid (dp_rv),
        .o_read_tag   (dp_tag),
        .o_read_cost  (dp_cost)
    );

    // result output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_acc  <= dp_acc;
            r_ovf  <= dp_ovf;
            r_rem  <= dp_rem;
            r_expl <= dp_expl;
            r_size <= dp_size;
            r_rv   <= dp_rv;
            r_tag  <= dp_tag;
            r_cost <= dp_cost;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_accepted      = r_acc;
    assign o_overflow      = r_ovf;
    assign o_removed_count = r_rem;
    assign o_explore       = r_expl;
    assign o_front_size    = r_size;
    assign o_read_valid    = r_rv;
    assign o_read_tag      = r_tag;
    assign o_read_cost_0   = r_cost[0];
    assign o_read_cost_1   = r_cost[1];
    assign o_read_cost_2   = r_cost[2];
    assign o_read_cost_3   = r_cost[3];

endmodule

>>> verif/tb.sv
// Testbench for pareto_archive_update: directed and random archive commands.
`timescale 1ns / 100ps

module tb;
    import pau_pkg::*;

    localparam int          FRONT_DEPTH = FRONT_DEPTH_DEF;
    localparam int          MAX_CAT     = MAX_CAT_DEF;
    localparam logic [1:0]  CMD_UNKNOWN = 2'd3;
    localparam int          PHASE_ITEMS = 170;
    localparam int          HOLD_CYCLES = 400;
    localparam int          QUIET_LIMIT = 2000;
    localparam int          N_PHASES    = 7;

    typedef logic [IN_LANES-1:0][VAL_W-1:0] cost_vec_t;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [TAG_W-1:0] tag;
        cost_vec_t        value;
        logic [IDX_W-1:0] read_index;
    } archive_cmd_t;

    typedef struct packed {
        logic                 accepted;
        logic                 overflow;
        logic [CNT_OUT_W-1:0] removed_count;
        logic                 explore;
        logic [CNT_OUT_W-1:0] front_size;
        logic                 read_valid;
        logic [TAG_W-1:0]     read_tag;
        cost_vec_t            read_cost;
    } archive_result_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [1:0]           i_cmd = '0;
    logic [TAG_W-1:0]     i_solution_tag = '0;
    logic [VAL_W-1:0]     i_value_0 = '0;
    logic [VAL_W-1:0]     i_value_1 = '0;
    logic [VAL_W-1:0]     i_value_2 = '0;
    logic [VAL_W-1:0]     i_value_3 = '0;
    logic [IDX_W-1:0]     i_read_index = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic                 o_accepted;
    logic                 o_overflow;
    logic [CNT_OUT_W-1:0] o_removed_count;
    logic                 o_explore;
    logic [CNT_OUT_W-1:0] o_front_size;
    logic                 o_read_valid;
    logic [TAG_W-1:0]     o_read_tag;
    logic [VAL_W-1:0]     o_read_cost_0;
    logic [VAL_W-1:0]     o_read_cost_1;
    logic [VAL_W-1:0]     o_read_cost_2;
    logic [VAL_W-1:0]     o_read_cost_3;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [2:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    pareto_archive_update dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_solution_tag  (i_solution_tag),
        .i_value_0       (i_value_0),
        .i_value_1       (i_value_1),
        .i_value_2       (i_value_2),
        .i_value_3       (i_value_3),
        .i_read_index    (i_read_index),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_accepted      (o_accepted),
        .o_overflow      (o_overflow),
        .o_removed_count (o_removed_count),
        .o_explore       (o_explore),
        .o_front_size    (o_front_size),
        .o_read_valid    (o_read_valid),
        .o_read_tag      (o_read_tag),
        .o_read_cost_0   (o_read_cost_0),
        .o_read_cost_1   (o_read_cost_1),
        .o_read_cost_2   (o_read_cost_2),
        .o_read_cost_3   (o_read_cost_3),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    archive_cmd_t    pending_cmds[$];
    archive_result_t expected_results[$];
    int              err_count = 0;

    // shadow archive
    cost_vec_t        front_cost[FRONT_DEPTH];
    logic [TAG_W-1:0] front_tag[FRONT_DEPTH];
    int               front_count;
    logic [CFG_W-1:0] cat_sel;

    bit sender_idle_en = 1'b1;
    bit recv_idle_en   = 1'b1;
    bit hold_req       = 1'b0;

    function automatic bit weakly_covers(cost_vec_t a, cost_vec_t b, int lanes);
        for (int k = 0; k < lanes; k++)
            if (a[k] < b[k]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic archive_result_t apply_archive_cmd(archive_cmd_t c);
        archive_result_t r;
        int              lanes;
        int              i;
        int              removed;
        bit              keep;
        r = '0;
        lanes = (cat_sel == 0) ? 1 : ((int'(cat_sel) > MAX_CAT) ? MAX_CAT : int'(cat_sel));
        case (c.cmd)
            CMD_INSERT: begin
                keep = 1'b1;
                removed = 0;
                i = 0;
                // removal shifts the tail down, so i stays put after a removal
                while (i < front_count) begin
                    if (weakly_covers(c.value, front_cost[i], lanes)) begin
                        for (int j = i; j + 1 < front_count; j++) begin
                            front_cost[j] = front_cost[j + 1];
                            front_tag[j]  = front_tag[j + 1];
                        end
                        front_count--;
                        removed++;
                    end else if (weakly_covers(front_cost[i], c.value, lanes)) begin
                        keep = 1'b0;
                        break;
                    end else begin
                        i++;
                    end
                end
                if (keep) begin
                    if (front_count < FRONT_DEPTH) begin
                        front_cost[front_count] = c.value;
                        front_tag[front_count]  = c.tag;
                        front_count++;
                        r.accepted = 1'b1;
                    end else begin
                        r.overflow = 1'b1;
                    end
                end
                r.removed_count = CNT_OUT_W'(removed);
            end
            CMD_QUERY: begin
                r.explore = (front_count == 0);
                for (int e = 0; e < front_count; e++)
                    for (int k = 0; k < lanes; k++)
                        if (c.value[k] > front_cost[e][k]) r.explore = 1'b1;
            end
            CMD_READ: begin
                if (int'(c.read_index) < front_count) begin
                    r.read_valid = 1'b1;
                    r.read_tag   = front_tag[c.read_index];
                    r.read_cost  = front_cost[c.read_index];
                end
            end
            default: begin
            end
        endcase
        r.front_size = CNT_OUT_W'(front_count);
        return r;
    endfunction

    function automatic archive_cmd_t make_cmd(logic [1:0] cmd, logic [TAG_W-1:0] tag,
                                              logic [VAL_W-1:0] v0, logic [VAL_W-1:0] v1,
                                              logic [VAL_W-1:0] v2, logic [VAL_W-1:0] v3,
                                              logic [IDX_W-1:0] idx);
        archive_cmd_t c;
        c.cmd        = cmd;
        c.tag        = tag;
        c.value      = {v3, v2, v1, v0};
        c.read_index = idx;
        return c;
    endfunction

    task automatic queue_cmd(archive_cmd_t c);
        pending_cmds = {pending_cmds, c};
    endtask

    // mixes narrow values (ties, dominance chains), anti-correlated fronts
    // (fill to overflow), full range, and near-max sweeps that clear the archive
    function automatic cost_vec_t rand_costs();
        cost_vec_t        v;
        int               sel;
        logic [VAL_W-1:0] r;
        sel = $urandom_range(0, 99);
        r = VAL_W'($urandom);
        for (int k = 0; k < IN_LANES; k++) begin
            if (sel < 35)
                v[k] = VAL_W'($urandom_range(0, 3));
            else if (sel < 65)
                v[k] = (k == 0) ? r : ((k == 1) ? ~r : VAL_W'($urandom_range(0, 7)));
            else if (sel < 85)
                v[k] = VAL_W'($urandom);
            else if (sel < 96)
                v[k] = $urandom_range(0, 1) ? '1 : '0;
            else
                v[k] = 16'hFFFF - VAL_W'($urandom_range(0, 3));
        end
        return v;
    endfunction

    function automatic archive_cmd_t rand_item();
        archive_cmd_t c;
        int           sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            c.cmd = CMD_INSERT;
        else if (sel < 70)
            c.cmd = CMD_QUERY;
        else if (sel < 95)
            c.cmd = CMD_READ;
        else
            c.cmd = CMD_UNKNOWN;
        c.tag        = TAG_W'($urandom);
        c.value      = rand_costs();
        c.read_index = IDX_W'($urandom);
        return c;
    endfunction

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            err_count++;
            if (err_count <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
        end
    endtask

    // item driver
    int gap_left = 0;
    always @(posedge i_clk) begin
        archive_cmd_t c;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left <= 0;
        end else if (!i_valid || o_ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                if (sender_idle_en && $urandom_range(0, 3) == 0) begin
                    gap_left <= int'($urandom_range(0, 12));
                    i_valid <= 1'b0;
                end else begin
                    c = pending_cmds.pop_front();
                    i_cmd          <= c.cmd;
                    i_solution_tag <= c.tag;
                    i_value_0      <= c.value[0];
                    i_value_1      <= c.value[1];
                    i_value_2      <= c.value[2];
                    i_value_3      <= c.value[3];
                    i_read_index   <= c.read_index;
                    i_valid        <= 1'b1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls and one long hold-off
    int  stall_left = 0;
    int  hold_cnt = 0;
    bit  hold_done = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
            hold_cnt <= hold_cnt + 1;
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if (recv_idle_en && $urandom_range(0, 4) == 0) begin
            stall_left <= int'($urandom_range(0, 12));
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // monitor: config tracking, result check, prediction on accept
    always @(posedge i_clk) begin
        archive_result_t want;
        archive_result_t got;
        archive_cmd_t    c;
        if (!i_rst_n) begin
            front_count = 0;
            cat_sel = ACTIVE_CAT_RST;
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_ACTIVE_CAT)
                cat_sel = pwdata[CFG_W-1:0];
            if (o_valid && i_ready) begin
                got.accepted      = o_accepted;
                got.overflow      = o_overflow;
                got.removed_count = o_removed_count;
                got.explore       = o_explore;
                got.front_size    = o_front_size;
                got.read_valid    = o_read_valid;
                got.read_tag      = o_read_tag;
                got.read_cost     = {o_read_cost_3, o_read_cost_2, o_read_cost_1, o_read_cost_0};
                if (expected_results.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: result with no item outstanding", $time);
                end else begin
                    want = expected_results.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(got.accepted));
                    check_field("overflow", 32'(want.overflow), 32'(got.overflow));
                    check_field("removed_count", 32'(want.removed_count),
                                32'(got.removed_count));
                    check_field("explore", 32'(want.explore), 32'(got.explore));
                    check_field("front_size", 32'(want.front_size), 32'(got.front_size));
                    check_field("read_valid", 32'(want.read_valid), 32'(got.read_valid));
                    check_field("read_tag", 32'(want.read_tag), 32'(got.read_tag));
                    check_field("read_cost_0", 32'(want.read_cost[0]), 32'(got.read_cost[0]));
                    check_field("read_cost_1", 32'(want.read_cost[1]), 32'(got.read_cost[1]));
                    check_field("read_cost_2", 32'(want.read_cost[2]), 32'(got.read_cost[2]));
                    check_field("read_cost_3", 32'(want.read_cost[3]), 32'(got.read_cost[3]));
                end
            end
            if (i_valid && o_ready) begin
                c.cmd        = i_cmd;
                c.tag        = i_solution_tag;
                c.value      = {i_value_3, i_value_2, i_value_1, i_value_0};
                c.read_index = i_read_index;
                want = apply_archive_cmd(c);
                expected_results = {expected_results, want};
            end
        end
    end

    // watchdog on cycles without any handshake
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready) || psel)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[pareto_archive_update] ERROR");
                $finish;
            end
        end
    end

    task automatic wait_drain();
        @(negedge i_clk);
        while (pending_cmds.size() > 0 || expected_results.size() > 0 || i_valid)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // register write, then read back
    task automatic set_active_categories(logic [CFG_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ACTIVE_CAT;
        pwdata  <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("active_categories", 32'(val), 32'(prdata[CFG_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    logic [CFG_W-1:0] phase_cat[N_PHASES] = '{3'd7, 3'd1, 3'd0, 3'd2, 3'd3, 3'd6, 3'd4};

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty archive
        queue_cmd(make_cmd(CMD_QUERY, '0, '0, '0, '0, '0, '0));
        queue_cmd(make_cmd(CMD_READ, '0, '0, '0, '0, '0, '0));
        // 16 mutually nondominated vectors fill the archive, the 17th overflows
        for (int k = 0; k <= FRONT_DEPTH; k++)
            queue_cmd(make_cmd(CMD_INSERT, 16'(k * 3001), 16'(k * 4000),
                               16'(65535 - k * 4000), 16'(k), 16'(16 - k),
                               4'(k)));
        queue_cmd(make_cmd(CMD_READ, '0, '0, '0, '0, '0, 4'hF));
        queue_cmd(make_cmd(CMD_QUERY, '0, '0, '0, '0, '0, '0));
        queue_cmd(make_cmd(CMD_QUERY, '0, '0, '1, '0, '0, '0));
        queue_cmd(make_cmd(CMD_UNKNOWN, '1, '1, '1, '1, '1, '1));
        // all-max vector clears the full archive, then a zero vector is rejected
        queue_cmd(make_cmd(CMD_INSERT, '1, '1, '1, '1, '1, '0));
        queue_cmd(make_cmd(CMD_INSERT, '0, '0, '0, '0, '0, '0));
        // equal vector replaces the entry
        queue_cmd(make_cmd(CMD_INSERT, 16'h5A5A, '1, '1, '1, '1, '0));
        queue_cmd(make_cmd(CMD_QUERY, '0, '1, '1, '1, '1, '0));
        queue_cmd(make_cmd(CMD_READ, '0, '0, '0, '0, '0, '0));
        wait_drain();

        for (int p = 0; p < N_PHASES; p++) begin
            set_active_categories(phase_cat[p]);
            sender_idle_en = (p != 3 && p != N_PHASES - 1);
            recv_idle_en   = (p != 3 && p != N_PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
                queue_cmd(rand_item());
            if (p == 1) begin
                while (pending_cmds.size() > PHASE_ITEMS / 2) @(negedge i_clk);
                hold_req = 1'b1;
            end
            wait_drain();
        end

        repeat (20) @(negedge i_clk);
        err_count += expected_results.size();
        if (err_count == 0)
            $display("[pareto_archive_update] OK");
        else
            $display("[pareto_archive_update] ERROR");
        $finish;
    end

endmodule

>>> pareto_archive_update.f
sv/pau_pkg.sv
sv/pau_ctrl.sv
sv/pau_dp.sv
sv/pareto_archive_update.sv
verif/tb.sv
